### hdl/csdm_pkg.sv
// Shared types and constants for the column surface depth map.
// No dependencies; every other file of the block but csdm_ram imports this package.
package csdm_pkg;

   localparam int VIEW_COLUMNS = 2048;
   localparam int COLUMN_W     = 11;
   localparam int ALPHA_W      = 8;
   localparam int DEPTH_W      = 9;
   localparam int LIMIT_W      = 8;
   localparam int RUN_ADDR_W   = (VIEW_COLUMNS > 1) ? $clog2(VIEW_COLUMNS) : 1;

   typedef logic [COLUMN_W-1:0]          column_type;
   typedef logic [ALPHA_W-1:0]           alpha_type;
   typedef logic signed [DEPTH_W-1:0]    depth_type;
   typedef logic [LIMIT_W-1:0]           limit_type;
   typedef logic [RUN_ADDR_W-1:0]        run_addr_type;

   localparam limit_type LIMIT_RESET = limit_type'(16);
   localparam depth_type DEPTH_NONE  = depth_type'(-1);
   localparam depth_type DEPTH_ZERO  = depth_type'(0);
   localparam depth_type DEPTH_ONE   = depth_type'(1);

endpackage

### hdl/csdm_req_if.sv
// Pixel request channel: valid/ready handshake with the pixel fields.
// Depends on csdm_pkg.
interface csdm_req_if;
   import csdm_pkg::*;

   logic       valid;
   logic       ready;
   column_type column;
   alpha_type  alpha;
   logic       in_bounds;
   logic       row_in_grid;
   logic       first_row;
   logic       visible;

   modport source (
      output valid, column, alpha, in_bounds, row_in_grid, first_row, visible,
      input  ready
   );
   modport sink (
      input  valid, column, alpha, in_bounds, row_in_grid, first_row, visible,
      output ready
   );
endinterface

### hdl/csdm_rsp_if.sv
// Depth response channel: valid/ready handshake with depth and column.
// Depends on csdm_pkg.
interface csdm_rsp_if;
   import csdm_pkg::*;

   logic       valid;
   logic       ready;
   depth_type  depth;
   column_type out_column;

   modport source (output valid, depth, out_column, input ready);
   modport sink   (input valid, depth, out_column, output ready);
endinterface

### hdl/csdm_csr_if.sv
// Configuration write channel carrying the depth limit.
// Depends on csdm_pkg.
interface csdm_csr_if;
   import csdm_pkg::*;

   logic      valid;
   logic      ready;
   limit_type data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### hdl/column_surface_depth_map.sv
// Top level of the column surface depth map.
// Depends on csdm_pkg, the three channel interfaces and csdm_ram.
//
// One pixel request per clock is accepted while responses are taken. A request
// passes through the stages in order before its response is presented:
// stage one holds the request while the run store read returns, stage two holds
// the updated depth (the store is written as the request leaves stage one), and
// stage three is the response register. The run store is a single RAM with one
// read and one write port. A request that follows one to the same column takes
// the new value through a bypass, so back-to-back pixels of one column need no
// bubble. Stalls on the response side back up through the stages without loss.
// Non-visible rows update the store but give no response; requests with a
// column past the view are dropped. The store has no clearing pass: a column
// must see its first row before its entry is read. The depth limit may be
// written at any time the block is idle. Neither the request channel nor the
// write channel is ready while reset is high.
module column_surface_depth_map (
   input  logic          clock,
   input  logic          reset,
   csdm_req_if.sink      req,
   csdm_rsp_if.source    rsp,
   csdm_csr_if.sink      csr
);
   import csdm_pkg::*;

   csdm_pkg::limit_type limit_ff, limit_in;

   logic       s1_valid_ff, s1_valid_in;
   column_type s1_column_ff, s1_column_in;
   logic       s1_matter_ff, s1_matter_in;
   logic       s1_first_ff, s1_first_in;
   logic       s1_in_grid_ff, s1_in_grid_in;
   logic       s1_visible_ff, s1_visible_in;
   logic       s1_fwd_hit_ff, s1_fwd_hit_in;
   depth_type  s1_fwd_data_ff, s1_fwd_data_in;

   logic       s2_valid_ff, s2_valid_in;
   column_type s2_column_ff, s2_column_in;
   depth_type  s2_depth_ff, s2_depth_in;

   logic       s3_valid_ff, s3_valid_in;
   column_type s3_column_ff, s3_column_in;
   depth_type  s3_depth_ff, s3_depth_in;

   logic       en1, en2, en3;
   logic       accept;
   logic       in_range;
   logic       wr_en;
   depth_type  rd_data;
   depth_type  base;
   depth_type  limit_s;
   depth_type  new_depth;

   assign en3      = !s3_valid_ff || rsp.ready;
   assign en2      = !s2_valid_ff || en3;
   assign en1      = !s1_valid_ff || en2;
   assign req.ready = en1 && !reset;
   assign accept   = req.valid && req.ready;
   assign in_range = int'(req.column) < VIEW_COLUMNS;
   assign wr_en    = s1_valid_ff && en2 && s1_in_grid_ff;
   assign csr.ready = !reset;

   csdm_ram #(
      .WIDTH (DEPTH_W),
      .DEPTH (VIEW_COLUMNS)
   ) u_run_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (run_addr_type'(s1_column_ff)),
      .wr_data (new_depth),
      .rd_en   (accept),
      .rd_addr (run_addr_type'(req.column)),
      .rd_data (rd_data)
   );

   // update the run counter
   assign base    = s1_fwd_hit_ff ? s1_fwd_data_ff : rd_data;
   assign limit_s = depth_type'({1'b0, limit_ff});

   always_comb begin
      if (!s1_in_grid_ff || !s1_matter_ff) begin
         new_depth = DEPTH_NONE;
      end else if (s1_first_ff) begin
         new_depth = limit_s;
      end else if (base < DEPTH_ZERO) begin
         new_depth = DEPTH_ZERO;
      end else if (base < limit_s) begin
         new_depth = base + DEPTH_ONE;
      end else begin
         new_depth = base;
      end
   end

   always_comb begin
      limit_in       = csr.valid ? csr.data : limit_ff;

      s1_valid_in    = s1_valid_ff;
      s1_column_in   = s1_column_ff;
      s1_matter_in   = s1_matter_ff;
      s1_first_in    = s1_first_ff;
      s1_in_grid_in  = s1_in_grid_ff;
      s1_visible_in  = s1_visible_ff;
      s1_fwd_hit_in  = s1_fwd_hit_ff;
      s1_fwd_data_in = s1_fwd_data_ff;
      if (en1) begin
         s1_valid_in    = accept && in_range && (req.row_in_grid || req.visible);
         s1_column_in   = req.column;
         s1_matter_in   = req.in_bounds && (req.alpha != '0);
         s1_first_in    = req.first_row;
         s1_in_grid_in  = req.row_in_grid;
         s1_visible_in  = req.visible;
         // bypass the write landing on the same edge as the read
         s1_fwd_hit_in  = wr_en && (s1_column_ff == req.column);
         s1_fwd_data_in = new_depth;
      end

      s2_valid_in  = s2_valid_ff;
      s2_column_in = s2_column_ff;
      s2_depth_in  = s2_depth_ff;
      if (en2) begin
         s2_valid_in  = s1_valid_ff && s1_visible_ff;
         s2_column_in = s1_column_ff;
         s2_depth_in  = new_depth;
      end

      s3_valid_in  = s3_valid_ff;
      s3_column_in = s3_column_ff;
      s3_depth_in  = s3_depth_ff;
      if (en3) begin
         s3_valid_in  = s2_valid_ff;
         s3_column_in = s2_column_ff;
         s3_depth_in  = s2_depth_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= LIMIT_RESET;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         limit_ff    <= limit_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
      s1_column_ff   <= s1_column_in;
      s1_matter_ff   <= s1_matter_in;
      s1_first_ff    <= s1_first_in;
      s1_in_grid_ff  <= s1_in_grid_in;
      s1_visible_ff  <= s1_visible_in;
      s1_fwd_hit_ff  <= s1_fwd_hit_in;
      s1_fwd_data_ff <= s1_fwd_data_in;
      s2_column_ff   <= s2_column_in;
      s2_depth_ff    <= s2_depth_in;
      s3_column_ff   <= s3_column_in;
      s3_depth_ff    <= s3_depth_in;
   end

   assign rsp.valid      = s3_valid_ff;
   assign rsp.depth      = s3_depth_ff;
   assign rsp.out_column = s3_column_ff;
endmodule

### hdl/csdm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module csdm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### hdl/csdm_checker.sv
// Port-level assertions for column_surface_depth_map, bound to the top level.
// Depends on csdm_pkg and column_surface_depth_map.
module csdm_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input csdm_pkg::depth_type  rsp_depth,
   input csdm_pkg::column_type rsp_out_column
);
   import csdm_pkg::*;

   a_reset_drains: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_depth) && $stable(rsp_out_column))
      else $error("stalled response changed");

   a_depth_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_depth >= DEPTH_NONE)
      else $error("depth below minus one");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response register");

   a_no_rsp_from_idle: assert property (@(posedge clock) disable iff (reset)
      !req_valid ##1 !req_valid ##1 !req_valid ##1 !rsp_valid |=> !rsp_valid)
      else $error("response without request");
endmodule

bind column_surface_depth_map csdm_checker u_csdm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_depth      (rsp.depth),
   .rsp_out_column (rsp.out_column)
);
